/* rtl/core/qpm_pkg.sv */
// ----------------------------------------------------------------------------
// qpm_pkg - shared types and constants for the quad PID motor mixer
// Field widths, fixed-point limits, reciprocal constants, command and
// status structs, and the residue tables for the error scaling.
// ----------------------------------------------------------------------------
`default_nettype none

package qpm_pkg;

  // stream payload widths
  localparam int InDataW  = 80;
  localparam int OutDataW = 64;
  localparam int DutyW    = 16;

  // configuration port
  localparam int CfgAddrW = 5;
  localparam int CfgDataW = 32;

  // internal widths
  localparam int NW    = 20;  // scaled stick/measurement difference, signed
  localparam int EW    = 29;  // Q16 error, signed
  localparam int EMagW = 28;
  localparam int DW    = 30;  // error difference, signed
  localparam int IntW  = 26;  // integral term, signed
  localparam int AxW   = 40;  // axis sum, signed
  localparam int MixW  = 28;  // clamped mix, signed

  // error scaling: n * 65536 / div, rounded, via reciprocal + residue table
  localparam int DivYaw   = 131;
  localparam int DivPr    = 10;
  localparam int RecYaw   = 512282;  // ceil(2^26 / 131)
  localparam int RecYawSh = 26;
  localparam int RecPr    = 6554;    // ceil(2^16 / 10)
  localparam int RecPrSh  = 16;

  // integral step: divide by 500 * 65536 = 2^18 * 125
  localparam logic [31:0] RecI      = 32'd2199023256;  // ceil(2^38 / 125)
  localparam int          RecISh    = 38;
  localparam logic [35:0] ISatBound = 36'd4194304000;  // 125 * 2^25
  localparam int          ISatQ     = 33554432;        // 2^25, beyond any reachable sum
  localparam int          RndI      = 16384000;

  localparam int          RndP    = 32768;
  localparam int          LimInt  = 16384000;          // 250.0 in Q16
  localparam logic [31:0] LimDpre = 32'd2576980378;
  localparam int          DerMul  = 500;
  localparam int          LimDer  = 19660800;          // 300.0 in Q16
  localparam int          LimMix  = 81920000;          // 1250.0 in Q16
  localparam int          MinThr  = 50;

  // axis codes
  localparam logic [1:0] AX_YAW   = 2'd0;
  localparam logic [1:0] AX_PITCH = 2'd1;
  localparam logic [1:0] AX_ROLL  = 2'd2;

  // multiplier operations
  typedef enum logic [2:0] {
    OP_NONE,
    OP_ERR,
    OP_P,
    OP_I,
    OP_D,
    OP_I2,
    OP_D2
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_E_MUL,
    ST_E_POST,
    ST_P_MUL,
    ST_I_MUL,
    ST_D_MUL,
    ST_I2_MUL,
    ST_D2_MUL,
    ST_D2_POST,
    ST_MIX,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    REG_BASE_THROTTLE,
    REG_KP_PITCH_ROLL,
    REG_KI_PITCH_ROLL,
    REG_KD_PITCH_ROLL,
    REG_KP_YAW_GAIN,
    REG_KI_YAW_GAIN,
    REG_KD_YAW_GAIN,
    REG_PWM_TOP
  } reg_idx_t;

  typedef struct packed {
    logic [11:0] base_throttle;
    logic [23:0] kp_pitch_roll;
    logic [23:0] ki_pitch_roll;
    logic [23:0] kd_pitch_roll;
    logic [23:0] kp_yaw_gain;
    logic [23:0] ki_yaw_gain;
    logic [23:0] kd_yaw_gain;
    logic [15:0] pwm_top;
  } cfg_t;

  typedef struct packed {
    logic       load;
    op_t        op;
    logic [1:0] axis;
    logic       mix;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } sts_t;

  // residue tables: round((b * 65536) / div) for remainder b
  typedef logic [15:0] tab_yaw_t [256];
  typedef logic [15:0] tab_pr_t [16];

  function automatic tab_yaw_t mk_tab_yaw();
    tab_yaw_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = (i < DivYaw) ? 16'((i * 65536 + DivYaw / 2) / DivYaw) : 16'd0;
    end
    return t;
  endfunction

  function automatic tab_pr_t mk_tab_pr();
    tab_pr_t t;
    for (int i = 0; i < 16; i++) begin
      t[i] = (i < DivPr) ? 16'((i * 65536 + DivPr / 2) / DivPr) : 16'd0;
    end
    return t;
  endfunction

  localparam tab_yaw_t TabYaw = mk_tab_yaw();
  localparam tab_pr_t  TabPr  = mk_tab_pr();

endpackage

`default_nettype wire

/* rtl/core/qpm_cfg.sv */
// ----------------------------------------------------------------------------
// qpm_cfg - configuration register file
// APB-style write/read access to throttle, gains and PWM top.
// ----------------------------------------------------------------------------
`default_nettype none

module qpm_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [qpm_pkg::CfgAddrW-1:0] cfg_paddr,
  input  wire logic [qpm_pkg::CfgDataW-1:0] cfg_pwdata,
  output logic      [qpm_pkg::CfgDataW-1:0] cfg_prdata,
  output logic                              cfg_pready,
  output qpm_pkg::cfg_t                     cfg
);

  qpm_pkg::cfg_t     cfg_r;
  qpm_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx        = qpm_pkg::reg_idx_t'(cfg_paddr[4:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_throttle <= 12'd400;
      cfg_r.kp_pitch_roll <= 24'd1048576;
      cfg_r.ki_pitch_roll <= 24'd66;
      cfg_r.kd_pitch_roll <= 24'd589824;
      cfg_r.kp_yaw_gain   <= 24'd229376;
      cfg_r.ki_yaw_gain   <= 24'd66;
      cfg_r.kd_yaw_gain   <= 24'd0;
      cfg_r.pwm_top       <= 16'd2399;
    end else if (wr_en) begin
      unique case (idx)
        qpm_pkg::REG_BASE_THROTTLE: cfg_r.base_throttle <= cfg_pwdata[11:0];
        qpm_pkg::REG_KP_PITCH_ROLL: cfg_r.kp_pitch_roll <= cfg_pwdata[23:0];
        qpm_pkg::REG_KI_PITCH_ROLL: cfg_r.ki_pitch_roll <= cfg_pwdata[23:0];
        qpm_pkg::REG_KD_PITCH_ROLL: cfg_r.kd_pitch_roll <= cfg_pwdata[23:0];
        qpm_pkg::REG_KP_YAW_GAIN:   cfg_r.kp_yaw_gain   <= cfg_pwdata[23:0];
        qpm_pkg::REG_KI_YAW_GAIN:   cfg_r.ki_yaw_gain   <= cfg_pwdata[23:0];
        qpm_pkg::REG_KD_YAW_GAIN:   cfg_r.kd_yaw_gain   <= cfg_pwdata[23:0];
        qpm_pkg::REG_PWM_TOP:       cfg_r.pwm_top       <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      qpm_pkg::REG_BASE_THROTTLE: cfg_prdata = 32'(cfg_r.base_throttle);
      qpm_pkg::REG_KP_PITCH_ROLL: cfg_prdata = 32'(cfg_r.kp_pitch_roll);
      qpm_pkg::REG_KI_PITCH_ROLL: cfg_prdata = 32'(cfg_r.ki_pitch_roll);
      qpm_pkg::REG_KD_PITCH_ROLL: cfg_prdata = 32'(cfg_r.kd_pitch_roll);
      qpm_pkg::REG_KP_YAW_GAIN:   cfg_prdata = 32'(cfg_r.kp_yaw_gain);
      qpm_pkg::REG_KI_YAW_GAIN:   cfg_prdata = 32'(cfg_r.ki_yaw_gain);
      qpm_pkg::REG_KD_YAW_GAIN:   cfg_prdata = 32'(cfg_r.kd_yaw_gain);
      qpm_pkg::REG_PWM_TOP:       cfg_prdata = 32'(cfg_r.pwm_top);
      default:                    cfg_prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/qpm_ctrl.sv */
// ----------------------------------------------------------------------------
// qpm_ctrl - sequencer for the PID/mixer datapath
// Walks the three axes through the shared multiplier, then mixes and
// loads the output register once it is free.
// ----------------------------------------------------------------------------
`default_nettype none

module qpm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire qpm_pkg::sts_t  sts,
  output qpm_pkg::cmd_t       cmd
);

  qpm_pkg::state_t state_r, state_nxt;
  logic [1:0]      axis_r, axis_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qpm_pkg::ST_IDLE;
      axis_r  <= qpm_pkg::AX_YAW;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    unique case (state_r)
      qpm_pkg::ST_IDLE: begin
        axis_nxt = qpm_pkg::AX_YAW;
        if (in_tvalid) state_nxt = qpm_pkg::ST_E_MUL;
      end
      qpm_pkg::ST_E_MUL:  state_nxt = qpm_pkg::ST_E_POST;
      qpm_pkg::ST_E_POST: state_nxt = qpm_pkg::ST_P_MUL;
      qpm_pkg::ST_P_MUL:  state_nxt = qpm_pkg::ST_I_MUL;
      qpm_pkg::ST_I_MUL:  state_nxt = qpm_pkg::ST_D_MUL;
      qpm_pkg::ST_D_MUL:  state_nxt = qpm_pkg::ST_I2_MUL;
      qpm_pkg::ST_I2_MUL: state_nxt = qpm_pkg::ST_D2_MUL;
      qpm_pkg::ST_D2_MUL: state_nxt = qpm_pkg::ST_D2_POST;
      qpm_pkg::ST_D2_POST: begin
        if (axis_r == qpm_pkg::AX_ROLL) begin
          state_nxt = qpm_pkg::ST_MIX;
        end else begin
          state_nxt = qpm_pkg::ST_E_MUL;
          axis_nxt  = axis_r + 2'd1;
        end
      end
      qpm_pkg::ST_MIX: state_nxt = qpm_pkg::ST_OUT;
      qpm_pkg::ST_OUT: begin
        if (!sts.out_full) state_nxt = qpm_pkg::ST_IDLE;
      end
      default: state_nxt = qpm_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready    = (state_r == qpm_pkg::ST_IDLE);
    cmd.load     = (state_r == qpm_pkg::ST_IDLE) && in_tvalid;
    cmd.axis     = axis_r;
    cmd.mix      = (state_r == qpm_pkg::ST_MIX);
    cmd.out_load = (state_r == qpm_pkg::ST_OUT) && !sts.out_full;
    unique case (state_r)
      qpm_pkg::ST_E_MUL:  cmd.op = qpm_pkg::OP_ERR;
      qpm_pkg::ST_P_MUL:  cmd.op = qpm_pkg::OP_P;
      qpm_pkg::ST_I_MUL:  cmd.op = qpm_pkg::OP_I;
      qpm_pkg::ST_D_MUL:  cmd.op = qpm_pkg::OP_D;
      qpm_pkg::ST_I2_MUL: cmd.op = qpm_pkg::OP_I2;
      qpm_pkg::ST_D2_MUL: cmd.op = qpm_pkg::OP_D2;
      default:            cmd.op = qpm_pkg::OP_NONE;
    endcase
  end

  a_accept_starts_yaw: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == qpm_pkg::ST_IDLE && in_tvalid)
      |=> (state_r == qpm_pkg::ST_E_MUL && axis_r == qpm_pkg::AX_YAW))
    else $error("accepted transaction did not start on the yaw axis");

  a_mix_after_roll: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == qpm_pkg::ST_MIX)
      |-> ($past(state_r) == qpm_pkg::ST_D2_POST && $past(axis_r) == qpm_pkg::AX_ROLL))
    else $error("mix entered before all three axes were done");

endmodule

`default_nettype wire

/* rtl/core/qpm_dp.sv */
// ----------------------------------------------------------------------------
// qpm_dp - PID and mixer datapath
// One shared 32x32 unsigned multiplier with a registered product; each
// product is post-processed in the cycle after it is issued. Signs are
// carried beside magnitudes since every rounding step is symmetric.
// ----------------------------------------------------------------------------
`default_nettype none

module qpm_dp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire qpm_pkg::cmd_t                  cmd,
  output qpm_pkg::sts_t                       sts,
  input  wire qpm_pkg::cfg_t                  cfg,
  // roll[10:0], pitch[21:11], yaw[32:22], pitch_angle[44:33],
  // roll_angle[56:45], yaw_rate_raw[72:57], zero pad above
  input  wire logic [qpm_pkg::InDataW-1:0]    in_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // duty_front_a[15:0], duty_b[31:16], duty_c[47:32], duty_d[63:48]
  output logic      [qpm_pkg::OutDataW-1:0]   out_tdata
);

  localparam int NW    = qpm_pkg::NW;
  localparam int EW    = qpm_pkg::EW;
  localparam int EMagW = qpm_pkg::EMagW;
  localparam int DW    = qpm_pkg::DW;
  localparam int IntW  = qpm_pkg::IntW;
  localparam int AxW   = qpm_pkg::AxW;
  localparam int MixW  = qpm_pkg::MixW;

  // input fields
  logic signed [10:0] s_roll, s_pitch, s_yaw;
  logic signed [11:0] a_pitch, a_roll;
  logic signed [15:0] rate;
  logic signed [NW-1:0] n_yaw_c, n_pitch_c, n_roll_c;

  assign s_roll  = in_tdata[10:0];
  assign s_pitch = in_tdata[21:11];
  assign s_yaw   = in_tdata[32:22];
  assign a_pitch = in_tdata[44:33];
  assign a_roll  = in_tdata[56:45];
  assign rate    = in_tdata[72:57];

  assign n_yaw_c   = (NW'(rate) <<< 1) - NW'(s_yaw) * NW'(393);
  assign n_pitch_c = NW'(0) - NW'(s_pitch) * NW'(3) - NW'(a_pitch);
  assign n_roll_c  = NW'(s_roll) * NW'(3) - NW'(a_roll);

  // state and working registers
  logic signed [NW-1:0]   n_r        [3];
  logic signed [EW-1:0]   prev_r     [3];
  logic signed [IntW-1:0] integral_r [3];
  logic signed [AxW-1:0]  axis_r     [3];
  logic signed [MixW-1:0] mix_r      [4];

  logic [63:0]            prod_r;
  qpm_pkg::op_t           op_q_r;
  logic signed [EW-1:0]   e_r;
  logic [EMagW-1:0]       e_mag_r;
  logic                   e_neg_r;
  logic [DW-1:0]          dmag_r;
  logic                   dneg_r;
  logic                   isat_r;
  logic [31:0]            iu_r;
  logic [31:0]            dd_r;
  logic                   out_valid_r;
  logic [qpm_pkg::OutDataW-1:0] out_data_r;

  // per-axis selection
  logic                 ax_yaw;
  logic signed [NW-1:0] n_sel;
  logic                 n_neg;
  logic [NW-1:0]        n_mag;
  logic [23:0]          kp_sel, ki_sel, kd_sel;

  assign ax_yaw = (cmd.axis == qpm_pkg::AX_YAW);
  assign n_sel  = n_r[cmd.axis];
  assign n_neg  = n_sel[NW-1];
  assign n_mag  = n_neg ? NW'(-n_sel) : NW'(n_sel);
  assign kp_sel = ax_yaw ? cfg.kp_yaw_gain : cfg.kp_pitch_roll;
  assign ki_sel = ax_yaw ? cfg.ki_yaw_gain : cfg.ki_pitch_roll;
  assign kd_sel = ax_yaw ? cfg.kd_yaw_gain : cfg.kd_pitch_roll;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  always_comb begin
    unique case (cmd.op)
      qpm_pkg::OP_ERR: begin
        mul_a = 32'(n_mag);
        mul_b = ax_yaw ? 32'(qpm_pkg::RecYaw) : 32'(qpm_pkg::RecPr);
      end
      qpm_pkg::OP_P: begin
        mul_a = 32'(kp_sel);
        mul_b = 32'(e_mag_r);
      end
      qpm_pkg::OP_I: begin
        mul_a = 32'(ki_sel);
        mul_b = 32'(e_mag_r);
      end
      qpm_pkg::OP_D: begin
        mul_a = 32'(kd_sel);
        mul_b = 32'(dmag_r);
      end
      qpm_pkg::OP_I2: begin
        mul_a = iu_r;
        mul_b = qpm_pkg::RecI;
      end
      qpm_pkg::OP_D2: begin
        mul_a = dd_r;
        mul_b = 32'(qpm_pkg::DerMul);
      end
      qpm_pkg::OP_NONE: begin
        mul_a = '0;
        mul_b = '0;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // error post: quotient from the reciprocal, fraction from the residue table
  logic [11:0]      e_q;
  logic [NW-1:0]    rem_c;
  logic [15:0]      e_frac;
  logic [EMagW-1:0] e_mag_c;

  assign e_q     = ax_yaw ? prod_r[qpm_pkg::RecYawSh +: 12] : prod_r[qpm_pkg::RecPrSh +: 12];
  assign rem_c   = n_mag - NW'(e_q) * (ax_yaw ? NW'(qpm_pkg::DivYaw) : NW'(qpm_pkg::DivPr));
  assign e_frac  = ax_yaw ? qpm_pkg::TabYaw[rem_c[7:0]] : qpm_pkg::TabPr[rem_c[3:0]];
  assign e_mag_c = {e_q, e_frac};

  // error difference for the derivative, refreshed every cycle
  logic signed [DW-1:0] diff_c;
  assign diff_c = DW'(e_r) - DW'(prev_r[cmd.axis]);

  // proportional post
  logic [53:0]           p_sum;
  logic signed [AxW-1:0] p_val;
  assign p_sum = 54'(prod_r[52:0]) + 54'(qpm_pkg::RndP);
  assign p_val = $signed({2'b00, p_sum[53:16]});

  // integral first post: divide by 2^18 with rounding bias
  logic [53:0] i_sum;
  logic [35:0] i_t;
  assign i_sum = 54'(prod_r[52:0]) + 54'(qpm_pkg::RndI);
  assign i_t   = i_sum[53:18];

  // integral second post: quotient by 125, accumulate, clamp
  logic [25:0]            i_q;
  logic signed [27:0]     i_qs, it_c;
  logic signed [IntW-1:0] it_new;
  assign i_q  = isat_r ? 26'(qpm_pkg::ISatQ) : prod_r[63:qpm_pkg::RecISh];
  assign i_qs = $signed({2'b00, i_q});
  assign it_c = e_neg_r ? 28'(integral_r[cmd.axis]) - i_qs : 28'(integral_r[cmd.axis]) + i_qs;

  always_comb begin
    priority if (it_c > 28'(qpm_pkg::LimInt)) begin
      it_new = IntW'(qpm_pkg::LimInt);
    end else if (it_c < -28'(qpm_pkg::LimInt)) begin
      it_new = -IntW'(qpm_pkg::LimInt);
    end else begin
      it_new = IntW'(it_c);
    end
  end

  // derivative second post: x500 already done, divide by 2^16, clamp
  logic [41:0]           d_sum;
  logic [25:0]           d_q;
  logic [25:0]           d_m;
  logic signed [AxW-1:0] d_val;
  assign d_sum = 42'(prod_r[40:0]) + 42'(qpm_pkg::RndP);
  assign d_q   = d_sum[41:16];
  assign d_m   = (d_q > 26'(qpm_pkg::LimDer)) ? 26'(qpm_pkg::LimDer) : d_q;
  assign d_val = dneg_r ? -AxW'($signed({1'b0, d_m})) : AxW'($signed({1'b0, d_m}));

  // mixer
  logic signed [AxW-1:0] y_ax, p_ax, r_ax;
  logic signed [AxW-1:0] sum_c [4];
  logic signed [MixW-1:0] mix_c [4];

  assign y_ax     = axis_r[qpm_pkg::AX_YAW];
  assign p_ax     = axis_r[qpm_pkg::AX_PITCH];
  assign r_ax     = axis_r[qpm_pkg::AX_ROLL];
  assign sum_c[0] = p_ax + r_ax + y_ax;
  assign sum_c[1] = p_ax - r_ax - y_ax;
  assign sum_c[2] = y_ax - p_ax - r_ax;
  assign sum_c[3] = r_ax - p_ax - y_ax;

  always_comb begin
    for (int m = 0; m < 4; m++) begin
      if (sum_c[m] > AxW'(qpm_pkg::LimMix)) begin
        mix_c[m] = MixW'(qpm_pkg::LimMix);
      end else if (sum_c[m] < -AxW'(qpm_pkg::LimMix)) begin
        mix_c[m] = -MixW'(qpm_pkg::LimMix);
      end else begin
        mix_c[m] = MixW'(sum_c[m]);
      end
    end
  end

  // duty: throttle plus mix, truncated, limited to 0..pwm_top
  logic                      motors_off;
  logic signed [29:0]        v_c   [4];
  logic [12:0]               vq_c  [4];
  logic [qpm_pkg::DutyW-1:0] duty_c [4];

  assign motors_off = (cfg.base_throttle < 12'(qpm_pkg::MinThr));

  always_comb begin
    for (int m = 0; m < 4; m++) begin
      v_c[m]  = $signed({2'b00, cfg.base_throttle, 16'h0000}) + 30'(mix_r[m]);
      vq_c[m] = v_c[m][28:16];
      if (motors_off || v_c[m][29]) begin
        duty_c[m] = '0;
      end else if (17'(vq_c[m]) > 17'(cfg.pwm_top)) begin
        duty_c[m] = cfg.pwm_top;
      end else begin
        duty_c[m] = 16'(vq_c[m]);
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_q_r      <= qpm_pkg::OP_NONE;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        prev_r[k]     <= '0;
        integral_r[k] <= '0;
      end
    end else begin
      op_q_r <= cmd.op;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (op_q_r == qpm_pkg::OP_I2) integral_r[cmd.axis] <= it_new;
      if (op_q_r == qpm_pkg::OP_D2) prev_r[cmd.axis] <= e_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    dmag_r <= diff_c[DW-1] ? DW'(-diff_c) : DW'(diff_c);
    dneg_r <= diff_c[DW-1];

    if (cmd.load) begin
      n_r[qpm_pkg::AX_YAW]   <= n_yaw_c;
      n_r[qpm_pkg::AX_PITCH] <= n_pitch_c;
      n_r[qpm_pkg::AX_ROLL]  <= n_roll_c;
    end

    unique case (op_q_r)
      qpm_pkg::OP_ERR: begin
        e_mag_r <= e_mag_c;
        e_neg_r <= n_neg;
        e_r     <= n_neg ? -$signed({1'b0, e_mag_c}) : $signed({1'b0, e_mag_c});
      end
      qpm_pkg::OP_P: begin
        axis_r[cmd.axis] <= e_neg_r ? -p_val : p_val;
      end
      qpm_pkg::OP_I: begin
        isat_r <= (i_t >= qpm_pkg::ISatBound);
        iu_r   <= i_t[31:0];
      end
      qpm_pkg::OP_D: begin
        dd_r <= (prod_r[53:0] > 54'(qpm_pkg::LimDpre)) ? qpm_pkg::LimDpre : prod_r[31:0];
      end
      qpm_pkg::OP_I2: begin
        axis_r[cmd.axis] <= axis_r[cmd.axis] + AxW'(it_new);
      end
      qpm_pkg::OP_D2: begin
        axis_r[cmd.axis] <= axis_r[cmd.axis] + d_val;
      end
      qpm_pkg::OP_NONE: ;
      default: ;
    endcase

    if (cmd.mix) begin
      for (int m = 0; m < 4; m++) mix_r[m] <= mix_c[m];
    end

    if (cmd.out_load) begin
      out_data_r <= {duty_c[3], duty_c[2], duty_c[1], duty_c[0]};
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign sts.out_full = out_valid_r && !out_tready;

  a_int_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (integral_r[0] <= IntW'(qpm_pkg::LimInt)) && (integral_r[0] >= -IntW'(qpm_pkg::LimInt)) &&
    (integral_r[1] <= IntW'(qpm_pkg::LimInt)) && (integral_r[1] >= -IntW'(qpm_pkg::LimInt)) &&
    (integral_r[2] <= IntW'(qpm_pkg::LimInt)) && (integral_r[2] >= -IntW'(qpm_pkg::LimInt)))
    else $error("integral term outside its anti-windup limit");

  a_err_residue: assert property (@(posedge clk) disable iff (!rst_n)
    (op_q_r == qpm_pkg::OP_ERR)
      |-> (ax_yaw ? (rem_c < NW'(qpm_pkg::DivYaw)) : (rem_c < NW'(qpm_pkg::DivPr))))
    else $error("reciprocal quotient off by one in error scaling");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("output register loaded while a result is pending");

endmodule

`default_nettype wire

/* rtl/core/quad_pid_motor_mixer.sv */
// ----------------------------------------------------------------------------
// quad_pid_motor_mixer - three-axis PID with quad-X motor mixing
// Each input transaction runs the three axes in turn on the shared 32x32
// multiplier, then the mix, then duty computation and output capture.
// A new transaction is accepted only when idle, once the previous result is
// in the output register; output stalls hold the sequence.
// Reset (synchronous, rst_n low) clears PID state, handshakes and control regs.
// ----------------------------------------------------------------------------
`default_nettype none

module quad_pid_motor_mixer (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // stream input
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  // stick_roll[10:0], stick_pitch[21:11], stick_yaw[32:22], pitch_angle[44:33],
  // roll_angle[56:45], yaw_rate_raw[72:57], zero pad [79:73]
  input  wire logic [qpm_pkg::InDataW-1:0]  in_tdata,
  // stream output
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // duty_front_a[15:0], duty_b[31:16], duty_c[47:32], duty_d[63:48]
  output logic      [qpm_pkg::OutDataW-1:0] out_tdata,
  // configuration
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [qpm_pkg::CfgAddrW-1:0] cfg_paddr,
  input  wire logic [qpm_pkg::CfgDataW-1:0] cfg_pwdata,
  output logic      [qpm_pkg::CfgDataW-1:0] cfg_prdata,
  output logic                              cfg_pready
);

  qpm_pkg::cfg_t cfg;
  qpm_pkg::cmd_t cmd;
  qpm_pkg::sts_t sts;

  qpm_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  qpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  qpm_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg        (cfg),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
